### hw/rtl/stlm_pkg.sv
package stlm_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] OP_PUSH_A = 2'd0;
  localparam logic [1:0] OP_PUSH_B = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH_A,
    CMD_PUSH_B,
    CMD_END
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     drain;
    logic                     ovf;
    logic                     nod;
  } res_t;

endpackage

### hw/rtl/stlm_in_if.sv
interface stlm_in_if import stlm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

### hw/rtl/stlm_out_if.sv
interface stlm_out_if import stlm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] merged_value;
  logic                     last_of_run;
  logic                     from_drain;
  logic                     overflow;
  logic                     no_data;

  modport source (output valid, output merged_value, output last_of_run, output from_drain,
                  output overflow, output no_data, input ready);
  modport sink   (input valid, input merged_value, input last_of_run, input from_drain,
                  input overflow, input no_data, output ready);
endinterface

### hw/rtl/stlm_ram.sv
module stlm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/stlm_front.sv
module stlm_front import stlm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  stlm_in_if.sink   in_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i
);

  cmd_t       buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       keep;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  always_comb begin
    keep         = 1'b1;
    cmd_in.value = in_i.value;
    cmd_in.cmd   = CMD_END;
    unique case (in_i.opcode)
      OP_PUSH_A: cmd_in.cmd = CMD_PUSH_A;
      OP_PUSH_B: cmd_in.cmd = CMD_PUSH_B;
      OP_END:    cmd_in.cmd = CMD_END;
      default:   keep       = 1'b0;
    endcase
  end

  assign in_i.ready  = (fill_q != 2'd2);
  assign push        = in_i.valid && in_i.ready && keep;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### hw/rtl/stlm_back.sv
module stlm_back import stlm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  output res_t res_o,
  output logic res_valid_o,
  input  logic res_ready_i
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MERGE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  function automatic logic [AW-1:0] wrap_pos(input logic [AW-1:0] h, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(c);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  logic [1:0]               state_q, state_d;
  logic [AW-1:0]            head_a_q, head_a_d, head_b_q, head_b_d;
  logic [CW-1:0]            cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                     side_q, side_d;
  logic                     rd_side_q, rd_side_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  res_t                     res_q, res_d;
  logic                     res_vld_q, res_vld_d;

  logic                     we_a, we_b, re_a, re_b;
  logic [AW-1:0]            raddr_a, raddr_b;
  logic [AW-1:0]            nxt_a, nxt_b, wpos_a, wpos_b;
  logic [DATA_W-1:0]        rdata_a, rdata_b;
  logic signed [DATA_W-1:0] hdata;
  logic [CW-1:0]            rd_cnt;
  logic                     out_free;
  logic                     take_o;
  logic                     emit;
  logic                     pop_en, pop_sel, clr;

  assign nxt_a    = wrap_pos(head_a_q, ONE_C);
  assign nxt_b    = wrap_pos(head_b_q, ONE_C);
  assign wpos_a   = wrap_pos(head_a_q, cnt_a_q);
  assign wpos_b   = wrap_pos(head_b_q, cnt_b_q);
  assign raddr_a  = (state_q == S_IDLE) ? head_a_q : nxt_a;
  assign raddr_b  = (state_q == S_IDLE) ? head_b_q : nxt_b;
  assign hdata    = rd_side_q ? $signed(rdata_b) : $signed(rdata_a);
  assign rd_cnt   = rd_side_q ? cnt_b_q : cnt_a_q;
  assign out_free = !res_vld_q || res_ready_i;
  // tie goes to B
  assign take_o   = side_q ? (hdata < val_q) : (hdata <= val_q);

  stlm_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (wpos_a),
    .wdata_i (cmd_i.value),
    .re_i    (re_a),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  stlm_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (wpos_b),
    .wdata_i (cmd_i.value),
    .re_i    (re_b),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  always_comb begin
    state_d     = state_q;
    head_a_d    = head_a_q;
    head_b_d    = head_b_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    side_d      = side_q;
    rd_side_d   = rd_side_q;
    val_d       = val_q;
    cmd_ready_o = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    re_a        = 1'b0;
    re_b        = 1'b0;
    emit        = 1'b0;
    res_d       = '0;
    pop_en      = 1'b0;
    pop_sel     = rd_side_q;
    clr         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.cmd)
            CMD_PUSH_A: begin
              if (cnt_a_q == DEPTH_C) begin
                emit      = 1'b1;
                res_d.ovf = 1'b1;
                res_d.last = 1'b1;
              end else begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + ONE_C;
                val_d   = cmd_i.value;
                side_d  = 1'b0;
                if (cnt_b_q != '0) begin
                  re_b      = 1'b1;
                  rd_side_d = 1'b1;
                  state_d   = S_MERGE;
                end
              end
            end
            CMD_PUSH_B: begin
              if (cnt_b_q == DEPTH_C) begin
                emit      = 1'b1;
                res_d.ovf = 1'b1;
                res_d.last = 1'b1;
              end else begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + ONE_C;
                val_d   = cmd_i.value;
                side_d  = 1'b1;
                if (cnt_a_q != '0) begin
                  re_a      = 1'b1;
                  rd_side_d = 1'b0;
                  state_d   = S_MERGE;
                end
              end
            end
            CMD_END: begin
              if (cnt_a_q == '0 && cnt_b_q == '0) begin
                emit       = 1'b1;
                res_d.nod  = 1'b1;
                res_d.last = 1'b1;
                clr        = 1'b1;
              end else if (cnt_a_q != '0) begin
                re_a      = 1'b1;
                rd_side_d = 1'b0;
                state_d   = S_DRAIN;
              end else begin
                re_b      = 1'b1;
                rd_side_d = 1'b1;
                state_d   = S_DRAIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_MERGE: begin
        if (out_free) begin
          emit   = 1'b1;
          pop_en = 1'b1;
          if (take_o) begin
            res_d.value = hdata;
            res_d.last  = (rd_cnt == ONE_C);
            if (rd_cnt != ONE_C) begin
              re_a = !rd_side_q;
              re_b = rd_side_q;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            // pushed word goes out before the head (smaller, or B on a tie) and ends the run
            res_d.value = val_q;
            res_d.last  = 1'b1;
            pop_sel     = side_q;
            state_d     = S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          emit        = 1'b1;
          pop_en      = 1'b1;
          res_d.value = hdata;
          res_d.drain = 1'b1;
          res_d.last  = (rd_cnt == ONE_C);
          if (rd_cnt == ONE_C) begin
            clr     = 1'b1;
            state_d = S_IDLE;
          end else begin
            re_a = !rd_side_q;
            re_b = rd_side_q;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (pop_en) begin
      if (pop_sel) begin
        head_b_d = nxt_b;
        cnt_b_d  = cnt_b_q - ONE_C;
      end else begin
        head_a_d = nxt_a;
        cnt_a_d  = cnt_a_q - ONE_C;
      end
    end
    if (clr) begin
      head_a_d = '0;
      head_b_d = '0;
      cnt_a_d  = '0;
      cnt_b_d  = '0;
    end
  end

  assign res_vld_d = emit ? 1'b1 : (res_ready_i ? 1'b0 : res_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_a_q  <= '0;
      head_b_q  <= '0;
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_a_q  <= head_a_d;
      head_b_q  <= head_b_d;
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q    <= side_d;
    rd_side_q <= rd_side_d;
    val_q     <= val_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

endmodule

### hw/rtl/sorted_two_list_merge_top.sv
// Two-way merge of sorted signed lists, one queue RAM per list.
// A push with nothing to merge, an overflow and an end on empty queues are handled without leaving
// idle; a push or end that yields merged or drained words gives them out one word per cycle while
// the output is not stalled.
// Reset is asynchronous, active low; it empties both queues.
module sorted_two_list_merge_top import stlm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  stlm_in_if.sink      in_i,
  stlm_out_if.source   out_o
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  res_t res;

  stlm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  stlm_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .res_o       (res),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready)
  );

  assign out_o.merged_value = res.value;
  assign out_o.last_of_run  = res.last;
  assign out_o.from_drain   = res.drain;
  assign out_o.overflow     = res.ovf;
  assign out_o.no_data      = res.nod;

`ifndef SYNTHESIS
  a_no_cmd_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !(cmd_valid && cmd_ready))
    else $error("command taken while result word stalled");

  a_front_full_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> cmd_valid)
    else $error("front stalls input with empty command queue");

  a_flag_word_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.overflow || out_o.no_data)) |->
      (out_o.last_of_run && !out_o.from_drain && out_o.merged_value == 0))
    else $error("malformed overflow or no-data word");
`endif

endmodule

### bench/tb_sorted_two_list_merge_top.sv
`timescale 1ns / 100ps

module tb_sorted_two_list_merge_top;
  import stlm_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_WORDS = 410;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int          VAL_MIN      = int'(32'h8000_0000);
  localparam int          VAL_MAX      = int'(32'h7FFF_FFFF);

  class merge_scoreboard;
    logic signed [DATA_W-1:0] list_a[$];
    logic signed [DATA_W-1:0] list_b[$];
    res_t                     merged_q[$];
    int unsigned              errors;
    int unsigned              checked;
    int unsigned              drained;
    int unsigned              overflows;
    int unsigned              empty_ends;

    function res_t make_word(logic signed [DATA_W-1:0] v, logic drain, logic ovf, logic nod);
      res_t w;
      w.value = v;
      w.last  = 1'b0;
      w.drain = drain;
      w.ovf   = ovf;
      w.nod   = nod;
      return w;
    endfunction

    function void note_input(logic [1:0] op, logic signed [DATA_W-1:0] v);
      res_t batch[$];
      case (op)
        OP_PUSH_A, OP_PUSH_B: begin
          if ((op == OP_PUSH_A ? list_a.size() : list_b.size()) >= DEPTH) begin
            batch = {batch, make_word('0, 1'b0, 1'b1, 1'b0)};
            overflows++;
          end else begin
            if (op == OP_PUSH_A) begin
              list_a = {list_a, v};
            end else begin
              list_b = {list_b, v};
            end
            // B wins ties
            while (list_a.size() != 0 && list_b.size() != 0) begin
              if (list_a[0] < list_b[0]) begin
                batch = {batch, make_word(list_a.pop_front(), 1'b0, 1'b0, 1'b0)};
              end else begin
                batch = {batch, make_word(list_b.pop_front(), 1'b0, 1'b0, 1'b0)};
              end
            end
          end
        end
        OP_END: begin
          if (list_a.size() == 0 && list_b.size() == 0) begin
            batch = {batch, make_word('0, 1'b0, 1'b0, 1'b1)};
            empty_ends++;
          end
          while (list_a.size() != 0) begin
            batch = {batch, make_word(list_a.pop_front(), 1'b1, 1'b0, 1'b0)};
            drained++;
          end
          while (list_b.size() != 0) begin
            batch = {batch, make_word(list_b.pop_front(), 1'b1, 1'b0, 1'b0)};
            drained++;
          end
        end
        default: ;
      endcase
      if (batch.size() != 0) begin
        batch[batch.size() - 1].last = 1'b1;
      end
      merged_q = {merged_q, batch};
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (merged_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("tb: unexpected word value=%0d last=%b drain=%b ovf=%b nod=%b",
                   got.value, got.last, got.drain, got.ovf, got.nod);
        end
        return;
      end
      want = merged_q.pop_front();
      if (got.value !== want.value || got.last !== want.last || got.drain !== want.drain ||
          got.ovf !== want.ovf || got.nod !== want.nod) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("tb: mismatch exp value=%0d last=%b drain=%b ovf=%b nod=%b",
                   want.value, want.last, want.drain, want.ovf, want.nod);
          $display("tb:          got value=%0d last=%b drain=%b ovf=%b nod=%b",
                   got.value, got.last, got.drain, got.ovf, got.nod);
        end
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  stlm_in_if       in_if ();
  stlm_out_if      out_if ();
  merge_scoreboard sb;
  bit              tx_burst;
  bit              rx_burst;
  int unsigned     commands_sent;

  sorted_two_list_merge_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int pick_value(int style);
    case (style)
      0: return int'($urandom);
      1: return int'($urandom_range(0, 16)) - 8;
      default: begin
        case ($urandom_range(0, 6))
          0: return VAL_MIN;
          1: return VAL_MIN + 1;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return VAL_MAX - 1;
          default: return VAL_MAX;
        endcase
      end
    endcase
  endfunction

  task automatic send_word(logic [1:0] op, logic signed [DATA_W-1:0] v);
    int unsigned gap;
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.value  <= v;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(op, v);
    if (op != OP_UNUSED) commands_sent++;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the input side until every outstanding word has come back
  task automatic drain_wait();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.merged_q.size() != 0);
  endtask

  initial begin
    int unsigned n;
    int unsigned pick;
    int unsigned target;
    int          style;
    int          a_vals[$];
    int          b_vals[$];
    logic [1:0]  op;
    sb           = new();
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.opcode <= OP_PUSH_A;
    in_if.value  <= '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_burst = 1'b0;
    send_word(OP_END, 32'sd0);
    send_word(OP_UNUSED, -32'sd1);
    send_word(OP_PUSH_A, VAL_MIN);
    send_word(OP_PUSH_B, VAL_MAX);
    send_word(OP_END, -32'sd1);
    send_word(OP_PUSH_B, 32'sd7);
    send_word(OP_PUSH_A, 32'sd7);
    // A holds one word; fill it and push once more to hit the full queue
    for (int i = 0; i < 16; i++) send_word(OP_PUSH_A, 100 * (i + 1));
    send_word(OP_END, 32'sd0);
    drain_wait();

    target = commands_sent + RANDOM_WORDS;
    while (commands_sent < target) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      style    = $urandom_range(0, 2);
      pick     = $urandom_range(0, 19);
      a_vals.delete();
      b_vals.delete();
      if (pick < 13) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 8);
        repeat (n) a_vals = {a_vals, pick_value(style)};
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 8);
        repeat (n) b_vals = {b_vals, pick_value(style)};
        a_vals.sort();
        b_vals.sort();
        while (a_vals.size() + b_vals.size() != 0) begin
          if (b_vals.size() == 0 || (a_vals.size() != 0 && $urandom_range(0, 1) == 0)) begin
            send_word(OP_PUSH_A, a_vals.pop_front());
          end else begin
            send_word(OP_PUSH_B, b_vals.pop_front());
          end
        end
        if ($urandom_range(0, 9) != 0) send_word(OP_END, $urandom);
      end else if (pick < 16) begin
        op = ($urandom_range(0, 1) != 0) ? OP_PUSH_B : OP_PUSH_A;
        repeat ($urandom_range(14, 19)) a_vals = {a_vals, pick_value(style)};
        a_vals.sort();
        foreach (a_vals[i]) send_word(op, a_vals[i]);
        send_word(OP_END, $urandom);
      end else begin
        repeat ($urandom_range(1, 8)) send_word(2'($urandom_range(0, 3)), $urandom);
      end
      if ($urandom_range(0, 9) == 0) drain_wait();
    end

    in_if.valid <= 1'b0;
    while (sb.merged_q.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    $display("tb: %0d commands sent, %0d words checked", commands_sent, sb.checked);
    $display("tb: %0d drained words, %0d overflows, %0d ends on empty queues",
             sb.drained, sb.overflows, sb.empty_ends);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned words;
    res_t        got;
    words        = 0;
    rx_burst     = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.value = out_if.merged_value;
      got.last  = out_if.last_of_run;
      got.drain = out_if.from_drain;
      got.ovf   = out_if.overflow;
      got.nod   = out_if.no_data;
      sb.check_result(got);
      words++;
      if (words % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
